// ===== rtl/core/mpl_pkg.sv =====
package mpl_pkg;

  localparam int CoordWidth      = 24;
  localparam int EpsShift        = 24;
  localparam int TolWidth        = 16;
  localparam int CountWidth      = 12;
  localparam int SlotWidth       = 11;
  localparam int CornerWidth     = 10;
  localparam int IndexWidth      = 11;
  localparam int DefMaxNodes     = 1024;
  localparam int DefMaxTriangles = 2048;
  localparam logic [TolWidth-1:0] TolReset = 16'd168;

  typedef enum logic [1:0] {
    KIND_NODE     = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_LOCATE   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic {
    REG_COUNT     = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRI,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_DIFF,
    ST_MUL,
    ST_CROSS,
    ST_NORM,
    ST_TOL,
    ST_TEST,
    ST_RES
  } state_e;

  typedef struct packed {
    kind_e                         kind;
    logic [SlotWidth-1:0]          slot;
    logic signed [CoordWidth-1:0]  coord_x;
    logic signed [CoordWidth-1:0]  coord_y;
    logic [CornerWidth-1:0]        corner_first;
    logic [CornerWidth-1:0]        corner_second;
    logic [CornerWidth-1:0]        corner_third;
  } in_t;

  typedef struct packed {
    logic                  found;
    logic [IndexWidth-1:0] hit_index;
  } out_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] px;
    logic signed [CoordWidth-1:0] py;
  } qry_t;

  typedef struct packed {
    logic valid;
    qry_t qry;
  } front_ctl_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_ctl_t;

endpackage

// ===== rtl/core/mpl_ram.sv =====
module mpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mpl_front.sv =====
module mpl_front #(
  parameter int MAX_NODES     = mpl_pkg::DefMaxNodes,
  parameter int MAX_TRIANGLES = mpl_pkg::DefMaxTriangles,
  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mpl_pkg::in_t          in_data_i,
  output logic                  node_we_o,
  output logic [NAW-1:0]        node_waddr_o,
  output logic [2*mpl_pkg::CoordWidth-1:0] node_wdata_o,
  output logic                  tri_we_o,
  output logic [TAW-1:0]        tri_waddr_o,
  output logic [3*NAW-1:0]      tri_wdata_o,
  output mpl_pkg::front_ctl_t   front_o,
  input  mpl_pkg::back_ctl_t    back_i
);

  localparam int unsigned Recip = (32'd1 << 20) / MAX_NODES;

  function automatic logic [NAW-1:0] corner_mod(input logic [mpl_pkg::CornerWidth-1:0] v);
    logic [31:0] prod;
    logic [31:0] rem;
    prod = 32'(v) * Recip;
    rem  = 32'(v) - (32'(prod[31:20]) * MAX_NODES);
    if (rem >= MAX_NODES) begin
      rem = rem - MAX_NODES;
    end
    return NAW'(rem);
  endfunction

  mpl_pkg::qry_t fifo_q [2];
  logic          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          accept, push, empty, full;

  assign empty = (cnt_q == 2'd0);
  assign full  = (cnt_q == 2'd2);

  always_comb begin
    case (in_data_i.kind)
      mpl_pkg::KIND_LOCATE:   in_stall_o = full;
      mpl_pkg::KIND_NODE:     in_stall_o = !empty || back_i.busy;
      mpl_pkg::KIND_TRIANGLE: in_stall_o = !empty || back_i.busy;
      default:                in_stall_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;
  assign push   = accept && (in_data_i.kind == mpl_pkg::KIND_LOCATE);

  assign node_we_o    = accept && (in_data_i.kind == mpl_pkg::KIND_NODE) &&
                        (32'(in_data_i.slot) < MAX_NODES);
  assign node_waddr_o = NAW'(in_data_i.slot);
  assign node_wdata_o = {in_data_i.coord_x, in_data_i.coord_y};
  assign tri_we_o     = accept && (in_data_i.kind == mpl_pkg::KIND_TRIANGLE) &&
                        (32'(in_data_i.slot) < MAX_TRIANGLES);
  assign tri_waddr_o  = TAW'(in_data_i.slot);
  assign tri_wdata_o  = {corner_mod(in_data_i.corner_first),
                         corner_mod(in_data_i.corner_second),
                         corner_mod(in_data_i.corner_third)};

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = !wptr_q;
    end
    if (back_i.pop) begin
      rptr_d = !rptr_q;
    end
    case ({push, back_i.pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{px: in_data_i.coord_x, py: in_data_i.coord_y};
    end
  end

  assign front_o.valid = !empty;
  assign front_o.qry   = fifo_q[rptr_q];

  assert property (@(posedge clk_i) disable iff (!rst_ni) back_i.pop |-> !empty)
    else $error("query pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (node_we_o || tri_we_o) |-> (empty && !back_i.busy))
    else $error("store write during a scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("query queue overflow");

endmodule

// ===== rtl/core/mpl_back.sv =====
module mpl_back #(
  parameter int MAX_NODES     = mpl_pkg::DefMaxNodes,
  parameter int MAX_TRIANGLES = mpl_pkg::DefMaxTriangles,
  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [mpl_pkg::CountWidth-1:0] count_i,
  input  logic [mpl_pkg::TolWidth-1:0]   tol_i,
  input  mpl_pkg::front_ctl_t   front_i,
  output mpl_pkg::back_ctl_t    back_o,
  output logic [TAW-1:0]        tri_raddr_o,
  input  logic [3*NAW-1:0]      tri_rdata_i,
  output logic [NAW-1:0]        node_raddr_o,
  input  logic [2*mpl_pkg::CoordWidth-1:0] node_rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mpl_pkg::out_t         out_data_o
);

  localparam int CW  = mpl_pkg::CoordWidth;
  localparam int TCW = $clog2(MAX_TRIANGLES + 1);
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 3;
  localparam int TW  = NW + mpl_pkg::TolWidth + 1;
  localparam int SW  = NW + mpl_pkg::EpsShift + 2;

  mpl_pkg::state_e state_q, state_d;
  logic [TCW-1:0]  idx_q, idx_d, lim_q, lim_d;
  mpl_pkg::qry_t   qry_q, qry_d;
  logic [3*NAW-1:0] corners_q, corners_d;
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q, x0_d, y0_d, x1_d, y1_d;
  logic signed [CW-1:0] x2, y2;
  logic signed [DW-1:0] dif_q [10];
  logic signed [DW-1:0] dif_d [10];
  logic signed [PW-1:0] prod_q [6];
  logic signed [PW-1:0] prod_d [6];
  logic signed [NW-1:0] d_q, n0_q, n1_q, d_d, n0_d, n1_d;
  logic signed [NW-1:0] da_q, na_q, nb_q, nc_q, da_d, na_d, nb_d, nc_d, n2;
  logic                 dz_q, dz_d;
  logic signed [TW-1:0] td_q, td_d;
  logic                 hit;
  logic                 out_valid_q, out_valid_d;
  mpl_pkg::out_t        out_q, out_d;
  mpl_pkg::out_t        res_q, res_d;

  function automatic logic coord_ok(input logic signed [NW-1:0] n,
                                    input logic signed [NW-1:0] d,
                                    input logic signed [TW-1:0] td);
    logic signed [SW-1:0] ns, ds, a, b;
    ns = SW'(n) <<< mpl_pkg::EpsShift;
    ds = SW'(d) <<< mpl_pkg::EpsShift;
    a  = ns + SW'(td);
    b  = ds + SW'(td) - ns;
    return !a[SW-1] && (a != '0) && !b[SW-1] && (b != '0);
  endfunction

  assign x2  = $signed(node_rdata_i[2*CW-1:CW]);
  assign y2  = $signed(node_rdata_i[CW-1:0]);
  assign n2  = d_q - n0_q - n1_q;
  assign hit = !dz_q && coord_ok(na_q, da_q, td_q) && coord_ok(nb_q, da_q, td_q) &&
               coord_ok(nc_q, da_q, td_q);

  assign tri_raddr_o = idx_q[TAW-1:0];

  always_comb begin
    case (state_q)
      mpl_pkg::ST_C0: node_raddr_o = tri_rdata_i[3*NAW-1:2*NAW];
      mpl_pkg::ST_C1: node_raddr_o = corners_q[2*NAW-1:NAW];
      default:        node_raddr_o = corners_q[NAW-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    qry_d       = qry_q;
    corners_d   = corners_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    dif_d       = dif_q;
    prod_d      = prod_q;
    d_d         = d_q;
    n0_d        = n0_q;
    n1_d        = n1_q;
    da_d        = da_q;
    na_d        = na_q;
    nb_d        = nb_q;
    nc_d        = nc_q;
    dz_d        = dz_q;
    td_d        = td_q;
    out_d       = out_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    back_o.pop  = 1'b0;
    back_o.busy = (state_q != mpl_pkg::ST_IDLE);
    case (state_q)
      mpl_pkg::ST_IDLE: begin
        if (front_i.valid) begin
          back_o.pop = 1'b1;
          qry_d      = front_i.qry;
          idx_d      = '0;
          if (32'(count_i) > MAX_TRIANGLES) begin
            lim_d = TCW'(MAX_TRIANGLES);
          end else begin
            lim_d = TCW'(count_i);
          end
          if (count_i == '0) begin
            res_d   = '{found: 1'b0, hit_index: '0};
            state_d = mpl_pkg::ST_RES;
          end else begin
            state_d = mpl_pkg::ST_TRI;
          end
        end
      end
      mpl_pkg::ST_TRI: state_d = mpl_pkg::ST_C0;
      mpl_pkg::ST_C0: begin
        corners_d = tri_rdata_i;
        state_d   = mpl_pkg::ST_C1;
      end
      mpl_pkg::ST_C1: begin
        x0_d    = x2;
        y0_d    = y2;
        state_d = mpl_pkg::ST_C2;
      end
      mpl_pkg::ST_C2: begin
        x1_d    = x2;
        y1_d    = y2;
        state_d = mpl_pkg::ST_DIFF;
      end
      mpl_pkg::ST_DIFF: begin
        dif_d[0] = DW'(x1_q) - DW'(x0_q);
        dif_d[1] = DW'(y1_q) - DW'(y0_q);
        dif_d[2] = DW'(x2) - DW'(x0_q);
        dif_d[3] = DW'(y2) - DW'(y0_q);
        dif_d[4] = DW'(x1_q) - DW'(qry_q.px);
        dif_d[5] = DW'(y1_q) - DW'(qry_q.py);
        dif_d[6] = DW'(x2) - DW'(qry_q.px);
        dif_d[7] = DW'(y2) - DW'(qry_q.py);
        dif_d[8] = DW'(x0_q) - DW'(qry_q.px);
        dif_d[9] = DW'(y0_q) - DW'(qry_q.py);
        state_d  = mpl_pkg::ST_MUL;
      end
      mpl_pkg::ST_MUL: begin
        prod_d[0] = dif_q[0] * dif_q[3];
        prod_d[1] = dif_q[2] * dif_q[1];
        prod_d[2] = dif_q[4] * dif_q[7];
        prod_d[3] = dif_q[6] * dif_q[5];
        prod_d[4] = dif_q[6] * dif_q[9];
        prod_d[5] = dif_q[8] * dif_q[7];
        state_d   = mpl_pkg::ST_CROSS;
      end
      mpl_pkg::ST_CROSS: begin
        d_d     = NW'(prod_q[0]) - NW'(prod_q[1]);
        n0_d    = NW'(prod_q[2]) - NW'(prod_q[3]);
        n1_d    = NW'(prod_q[4]) - NW'(prod_q[5]);
        state_d = mpl_pkg::ST_NORM;
      end
      mpl_pkg::ST_NORM: begin
        dz_d = (d_q == '0);
        if (d_q[NW-1]) begin
          da_d = -d_q;
          na_d = -n0_q;
          nb_d = -n1_q;
          nc_d = -n2;
        end else begin
          da_d = d_q;
          na_d = n0_q;
          nb_d = n1_q;
          nc_d = n2;
        end
        state_d = mpl_pkg::ST_TOL;
      end
      mpl_pkg::ST_TOL: begin
        td_d    = $signed({1'b0, tol_i}) * da_q;
        state_d = mpl_pkg::ST_TEST;
      end
      mpl_pkg::ST_TEST: begin
        if (hit) begin
          res_d   = '{found: 1'b1, hit_index: mpl_pkg::IndexWidth'(idx_q)};
          state_d = mpl_pkg::ST_RES;
        end else if (idx_q + TCW'(1) == lim_q) begin
          res_d   = '{found: 1'b0, hit_index: '0};
          state_d = mpl_pkg::ST_RES;
        end else begin
          idx_d   = idx_q + TCW'(1);
          state_d = mpl_pkg::ST_TRI;
        end
      end
      mpl_pkg::ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = mpl_pkg::ST_IDLE;
        end
      end
      default: state_d = mpl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      lim_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q     <= qry_d;
    corners_q <= corners_d;
    x0_q      <= x0_d;
    y0_q      <= y0_d;
    x1_q      <= x1_d;
    y1_q      <= y1_d;
    dif_q     <= dif_d;
    prod_q    <= prod_d;
    d_q       <= d_d;
    n0_q      <= n0_d;
    n1_q      <= n1_d;
    da_q      <= da_d;
    na_q      <= na_d;
    nb_q      <= nb_d;
    nc_q      <= nc_d;
    dz_q      <= dz_d;
    td_q      <= td_d;
    out_q     <= out_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpl_pkg::ST_TRI) |-> (idx_q < lim_q))
    else $error("scan index beyond triangle count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> (out_data_o.hit_index == '0))
    else $error("nonzero index on a miss");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_o.pop |=> (state_q == mpl_pkg::ST_TRI) || (state_q == mpl_pkg::ST_RES))
    else $error("query popped without starting a scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpl_pkg::ST_RES) && out_valid_q && out_stall_i |=>
      (state_q == mpl_pkg::ST_RES))
    else $error("result dropped while output held");

endmodule

// ===== rtl/core/mesh_point_location.sv =====
// Point location in a 2D triangle mesh. Node and triangle write transactions
// land in on-chip stores; a store entry must be written before any query
// reads it (the stores are not cleared after reset). A locate transaction
// scans triangles 0 .. min(triangle_count, MAX_TRIANGLES)-1 and returns the
// first one that contains the point within the tolerance, or a miss. For each
// triangle examined, a locate makes one corner read, three reads through the
// single node-store read port and a six-step exact arithmetic chain. Up to two
// queries wait in a queue ahead of the scan engine; writes are held off until
// the scan and queue drain.
module mesh_point_location #(
  parameter int MAX_NODES     = mpl_pkg::DefMaxNodes,
  parameter int MAX_TRIANGLES = mpl_pkg::DefMaxTriangles
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mpl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mpl_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CW  = mpl_pkg::CoordWidth;

  logic [mpl_pkg::CountWidth-1:0] count_q, count_d;
  logic [mpl_pkg::TolWidth-1:0]   tol_q, tol_d;
  mpl_pkg::reg_e                  reg_sel;

  logic                 node_we, tri_we;
  logic [NAW-1:0]       node_waddr, node_raddr;
  logic [2*CW-1:0]      node_wdata, node_rdata;
  logic [TAW-1:0]       tri_waddr, tri_raddr;
  logic [3*NAW-1:0]     tri_wdata, tri_rdata;
  mpl_pkg::front_ctl_t  front_ctl;
  mpl_pkg::back_ctl_t   back_ctl;

  assign reg_sel = mpl_pkg::reg_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    count_d = count_q;
    tol_d   = tol_q;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        mpl_pkg::REG_COUNT:     count_d = pwdata[mpl_pkg::CountWidth-1:0];
        mpl_pkg::REG_TOLERANCE: tol_d   = pwdata[mpl_pkg::TolWidth-1:0];
        default:                count_d = count_q;
      endcase
    end
    case (reg_sel)
      mpl_pkg::REG_COUNT:     prdata = 32'(count_q);
      mpl_pkg::REG_TOLERANCE: prdata = 32'(tol_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tol_q   <= mpl_pkg::TolReset;
    end else begin
      count_q <= count_d;
      tol_q   <= tol_d;
    end
  end

  mpl_front #(
    .MAX_NODES     (MAX_NODES),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .node_we_o    (node_we),
    .node_waddr_o (node_waddr),
    .node_wdata_o (node_wdata),
    .tri_we_o     (tri_we),
    .tri_waddr_o  (tri_waddr),
    .tri_wdata_o  (tri_wdata),
    .front_o      (front_ctl),
    .back_i       (back_ctl)
  );

  mpl_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  mpl_ram #(
    .WIDTH (3 * NAW),
    .DEPTH (MAX_TRIANGLES)
  ) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_waddr),
    .wdata_i (tri_wdata),
    .raddr_i (tri_raddr),
    .rdata_o (tri_rdata)
  );

  mpl_back #(
    .MAX_NODES     (MAX_NODES),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .count_i      (count_q),
    .tol_i        (tol_q),
    .front_i      (front_ctl),
    .back_o       (back_ctl),
    .tri_raddr_o  (tri_raddr),
    .tri_rdata_i  (tri_rdata),
    .node_raddr_o (node_raddr),
    .node_rdata_i (node_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== sim/tb_mesh_point_location.sv =====
`timescale 1ns / 1ps

module tb_mesh_point_location;

  localparam int BaseSet = 8;
  localparam int CoordMax = 8388607;
  localparam int CoordMin = -8388608;
  localparam int CW = mpl_pkg::CoordWidth;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  mpl_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  mpl_pkg::out_t out_data_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  logic signed [CW-1:0]              node_x_mem [mpl_pkg::DefMaxNodes];
  logic signed [CW-1:0]              node_y_mem [mpl_pkg::DefMaxNodes];
  logic [mpl_pkg::CornerWidth-1:0]   corner_mem [mpl_pkg::DefMaxTriangles][3];
  logic [mpl_pkg::CountWidth-1:0]    scan_count;
  logic [mpl_pkg::TolWidth-1:0]      slack;
  mpl_pkg::out_t                     located_q [$];
  int                                errors;
  bit                                quiet;

  mesh_point_location u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic signed [127:0] wedge(input logic signed [127:0] ax, ay, bx, by);
    return ax * by - bx * ay;
  endfunction

  function automatic bit bary_ok(input logic signed [127:0] n, d, td);
    logic signed [127:0] ns;
    ns = n <<< mpl_pkg::EpsShift;
    return (ns + td > 0) && ((d <<< mpl_pkg::EpsShift) + td - ns > 0);
  endfunction

  function automatic bit covers(input int t, input logic signed [127:0] px, py);
    logic signed [127:0] x0, y0, x1, y1, x2, y2, d, n0, n1, n2, td;
    x0 = node_x_mem[corner_mem[t][0]];
    y0 = node_y_mem[corner_mem[t][0]];
    x1 = node_x_mem[corner_mem[t][1]];
    y1 = node_y_mem[corner_mem[t][1]];
    x2 = node_x_mem[corner_mem[t][2]];
    y2 = node_y_mem[corner_mem[t][2]];
    d  = wedge(x1 - x0, y1 - y0, x2 - x0, y2 - y0);
    n0 = wedge(x1 - px, y1 - py, x2 - px, y2 - py);
    n1 = wedge(x2 - px, y2 - py, x0 - px, y0 - py);
    n2 = d - n0 - n1;
    if (d == 0) return 1'b0;
    if (d < 0) begin
      d  = -d;
      n0 = -n0;
      n1 = -n1;
      n2 = -n2;
    end
    td = d * $signed({112'd0, slack});
    return bary_ok(n0, d, td) && bary_ok(n1, d, td) && bary_ok(n2, d, td);
  endfunction

  function automatic mpl_pkg::out_t locate(input logic signed [127:0] px, py);
    mpl_pkg::out_t r;
    int            lim;
    r   = '0;
    lim = (scan_count > mpl_pkg::DefMaxTriangles) ? mpl_pkg::DefMaxTriangles :
          int'(scan_count);
    for (int i = 0; i < lim; i++) begin
      if (covers(i, px, py)) begin
        r.found     = 1'b1;
        r.hit_index = i[mpl_pkg::IndexWidth-1:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic void apply_item(input mpl_pkg::in_t it);
    case (it.kind)
      mpl_pkg::KIND_NODE: begin
        if (it.slot < mpl_pkg::DefMaxNodes) begin
          node_x_mem[it.slot] = it.coord_x;
          node_y_mem[it.slot] = it.coord_y;
        end
      end
      mpl_pkg::KIND_TRIANGLE: begin
        corner_mem[it.slot][0] = it.corner_first;
        corner_mem[it.slot][1] = it.corner_second;
        corner_mem[it.slot][2] = it.corner_third;
      end
      mpl_pkg::KIND_LOCATE: located_q = {located_q, locate(it.coord_x, it.coord_y)};
      default: ;
    endcase
  endfunction

  function automatic mpl_pkg::in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(mpl_pkg::in_t)-1:0];
  endfunction

  function automatic mpl_pkg::in_t node_item(input int slot, input int x, input int y);
    mpl_pkg::in_t it;
    it         = noise_item();
    it.kind    = mpl_pkg::KIND_NODE;
    it.slot    = slot[mpl_pkg::SlotWidth-1:0];
    it.coord_x = x[CW-1:0];
    it.coord_y = y[CW-1:0];
    return it;
  endfunction

  function automatic mpl_pkg::in_t tri_item(input int slot, input int a, input int b,
                                            input int c);
    mpl_pkg::in_t it;
    it               = noise_item();
    it.kind          = mpl_pkg::KIND_TRIANGLE;
    it.slot          = slot[mpl_pkg::SlotWidth-1:0];
    it.corner_first  = a[mpl_pkg::CornerWidth-1:0];
    it.corner_second = b[mpl_pkg::CornerWidth-1:0];
    it.corner_third  = c[mpl_pkg::CornerWidth-1:0];
    return it;
  endfunction

  function automatic mpl_pkg::in_t locate_item(input int x, input int y);
    mpl_pkg::in_t it;
    it         = noise_item();
    it.kind    = mpl_pkg::KIND_LOCATE;
    it.coord_x = x[CW-1:0];
    it.coord_y = y[CW-1:0];
    return it;
  endfunction

  function automatic int clamp(input int v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic int rand_coord();
    logic signed [CW-1:0] full;
    full = CW'($urandom());
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 131071)) - 65536;
    return full;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic send_item(input mpl_pkg::in_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (located_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_reg(input mpl_pkg::reg_e r, input int v);
    in_valid_i <= 1'b0;
    psel       <= 1'b1;
    penable    <= 1'b0;
    pwrite     <= 1'b1;
    paddr      <= {r, 2'b00};
    pwdata     <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == mpl_pkg::REG_COUNT) scan_count = v[mpl_pkg::CountWidth-1:0];
    else slack = v[mpl_pkg::TolWidth-1:0];
    @(posedge clk_i);
  endtask

  task automatic test_fill_mesh();
    send_item(node_item(0, 0, 0));
    send_item(node_item(1, 16384, 0));
    send_item(node_item(2, 0, 16384));
    send_item(node_item(3, 16384, 16384));
    send_item(node_item(4, CoordMax, CoordMax));
    send_item(node_item(5, CoordMin, CoordMin));
    send_item(node_item(6, CoordMax, CoordMin));
    send_item(node_item(7, CoordMin, CoordMax));
    send_item(tri_item(0, 0, 1, 2));
    send_item(tri_item(1, 1, 3, 2));
    send_item(tri_item(2, 0, 0, 1));
    send_item(tri_item(3, 4, 5, 6));
    send_item(tri_item(4, 5, 4, 7));
    send_item(tri_item(5, 0, 2, 1));
    send_item(tri_item(6, 0, 1, 3));
    send_item(tri_item(7, 7, 6, 4));
  endtask

  task automatic test_edge_cases();
    send_item(locate_item(1024, 1024));
    wait_idle();
    set_reg(mpl_pkg::REG_COUNT, 4095);
    set_reg(mpl_pkg::REG_TOLERANCE, 0);
    send_item(locate_item(1024, 1024));
    wait_idle();
    set_reg(mpl_pkg::REG_COUNT, mpl_pkg::DefMaxTriangles);
    send_item(locate_item(2048, 512));
    wait_idle();
    set_reg(mpl_pkg::REG_COUNT, BaseSet);
    send_item(locate_item(0, 1000));
    send_item(locate_item(0, 0));
    send_item(locate_item(CoordMax, CoordMin));
    send_item(noise_item() | mpl_pkg::in_t'({mpl_pkg::KIND_NONE, 89'd0}));
    send_item(node_item(2047, rand_coord(), rand_coord()));
    send_item(tri_item(2047, 1023, 512, 1));
    wait_idle();
    set_reg(mpl_pkg::REG_TOLERANCE, 65535);
    send_item(locate_item(0, 1000));
    send_item(locate_item(-10, 5));
    send_item(locate_item(8192, 8192));
    wait_idle();
  endtask

  task automatic test_random_phase(input int items, input int cnt, input int tol,
                                   input bit q);
    int done, pick, t, m, x, y;
    mpl_pkg::in_t it;
    quiet = q;
    set_reg(mpl_pkg::REG_COUNT, cnt);
    set_reg(mpl_pkg::REG_TOLERANCE, tol);
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        t = (scan_count > 0 && scan_count <= BaseSet) ?
            $urandom_range(0, scan_count - 1) : $urandom_range(0, BaseSet - 1);
        m = $urandom_range(0, 2);
        x = node_x_mem[corner_mem[t][m]];
        y = node_y_mem[corner_mem[t][m]];
        if ($urandom_range(0, 2) != 0) begin
          x = (x + int'(node_x_mem[corner_mem[t][(m + 1) % 3]])) / 2;
          y = (y + int'(node_y_mem[corner_mem[t][(m + 1) % 3]])) / 2;
          x = (2 * x + int'(node_x_mem[corner_mem[t][(m + 2) % 3]])) / 3;
          y = (2 * y + int'(node_y_mem[corner_mem[t][(m + 2) % 3]])) / 3;
        end
        if ($urandom_range(0, 1) != 0) begin
          x = clamp(x + int'($urandom_range(0, 128)) - 64);
          y = clamp(y + int'($urandom_range(0, 128)) - 64);
        end
        it = locate_item(x, y);
      end else if (pick < 60) begin
        it = locate_item(rand_coord(), rand_coord());
      end else if (pick < 75) begin
        t  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, BaseSet - 1) :
             $urandom_range(0, 2047);
        it = node_item(t, rand_coord(), rand_coord());
      end else if (pick < 90) begin
        if ($urandom_range(0, 9) < 6)
          it = tri_item($urandom_range(0, BaseSet - 1), $urandom_range(0, BaseSet - 1),
                        $urandom_range(0, BaseSet - 1), $urandom_range(0, BaseSet - 1));
        else
          it = tri_item($urandom_range(BaseSet, 2047), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        it      = noise_item();
        it.kind = mpl_pkg::KIND_NONE;
      end
      if (it.kind != mpl_pkg::KIND_NONE) done++;
      send_item(it);
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    mpl_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (located_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", out_data_o));
      end else begin
        want = located_q.pop_front();
        if (out_data_o.found !== want.found)
          flag_mismatch($sformatf("found %b, want %b", out_data_o.found, want.found));
        if (out_data_o.hit_index !== want.hit_index)
          flag_mismatch($sformatf("hit_index %0d, want %0d",
                                  out_data_o.hit_index, want.hit_index));
      end
    end
  end

  initial begin
    int n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    #5ms;
    $display("mesh_point_location: mismatch");
    $finish;
  end

  initial begin
    errors     = 0;
    quiet      = 1'b0;
    scan_count = '0;
    slack      = mpl_pkg::TolReset;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_mesh();
    test_edge_cases();
    test_random_phase(40, BaseSet, int'(mpl_pkg::TolReset), 1'b0);
    test_random_phase(40, 1, 0, 1'b0);
    test_random_phase(40, $urandom_range(2, BaseSet), 65535, 1'b0);
    test_random_phase(40, BaseSet, $urandom_range(0, 65535), 1'b1);
    test_random_phase(40, 5, $urandom_range(0, 4096), 1'b0);
    test_random_phase(40, BaseSet, 12, 1'b0);
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (located_q.size() != 0) flag_mismatch("results still outstanding");
    if (errors == 0) begin
      $display("mesh_point_location: match");
    end else begin
      $display("mesh_point_location: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mpl_pkg.sv
rtl/core/mpl_ram.sv
rtl/core/mpl_front.sv
rtl/core/mpl_back.sv
rtl/core/mesh_point_location.sv
sim/tb_mesh_point_location.sv
